// ----- sv/ppre_pkg.sv -----
`default_nettype none
package ppre_pkg;

  localparam int unsigned PLANE_BYTES_DEF = 32768;
  localparam int unsigned NUM_PLANES      = 4;
  localparam int unsigned LW_W            = 11;
  localparam int unsigned BPL_W           = 8;
  localparam int unsigned X_W             = 10;
  localparam int unsigned Y_W             = 9;
  localparam int unsigned SUM_W           = 18;
  localparam int unsigned CFG_IDX_W       = 1;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST = LW_W'(640);

  localparam logic [1:0] KIND_PIX_WR  = 2'd0;
  localparam logic [1:0] KIND_PIX_RD  = 2'd1;
  localparam logic [1:0] KIND_SPAN_WR = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RASTER_OP  = 1'b1;

  localparam logic [7:0] MASK_MSB = 8'b1000_0000;

  typedef enum logic [1:0] {
    ROP_SET = 2'd0,
    ROP_AND = 2'd1,
    ROP_OR  = 2'd2,
    ROP_XOR = 2'd3
  } rop_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic       re;
    logic       we;
    logic [7:0] mask;
    rop_t       op;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ----- sv/ppre_agen.sv -----
`default_nettype none
module ppre_agen #(
  parameter int unsigned PLANE_BYTES = ppre_pkg::PLANE_BYTES_DEF,
  parameter int unsigned AW          = $clog2(PLANE_BYTES)
) (
  input  wire logic                     clk,
  input  wire logic                     load,
  input  wire logic [ppre_pkg::X_W-1:0]  pos_x,
  input  wire logic [ppre_pkg::Y_W-1:0]  pos_y,
  input  wire logic [ppre_pkg::LW_W-1:0] line_width,
  output logic      [AW-1:0]            addr_r,
  output logic                          bad_r
);
  import ppre_pkg::*;

  logic [BPL_W-1:0] bpl;
  logic [BPL_W-1:0] col;
  logic [SUM_W-1:0] sum;
  logic             bad_nxt;

  always_comb begin
    bpl     = line_width[LW_W-1:3];
    col     = {1'b0, pos_x[X_W-1:3]};
    sum     = (SUM_W'(pos_y) * SUM_W'(bpl)) + SUM_W'(col);
    bad_nxt = (col >= bpl) || (sum >= SUM_W'(PLANE_BYTES));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= sum[AW-1:0];
      bad_r  <= bad_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ppre_lane.sv -----
`default_nettype none
module ppre_lane #(
  parameter int unsigned PLANE_BYTES = ppre_pkg::PLANE_BYTES_DEF,
  parameter int unsigned AW          = $clog2(PLANE_BYTES)
) (
  input  wire logic                clk,
  input  wire ppre_pkg::lane_ctl_t ctl,
  input  wire logic [AW-1:0]       addr,
  input  wire logic [7:0]          bits,
  output logic      [7:0]          rdata_r
);
  import ppre_pkg::*;

  logic [7:0] mem [PLANE_BYTES];
  logic [7:0] val;
  logic [7:0] wdata;

  always_comb begin
    unique case (ctl.op)
      ROP_SET: val = bits;
      ROP_AND: val = rdata_r & bits;
      ROP_OR:  val = rdata_r | bits;
      ROP_XOR: val = rdata_r ^ bits;
      default: val = bits;
    endcase
    wdata = (rdata_r & ~ctl.mask) | (val & ctl.mask);
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/planar_pixel_rop_engine.sv -----
// An accepted item is registered, read from the one-port plane RAMs in the read
// state, then written back with its result registered in the write state once the
// output can take it; a new item is taken when idle or as the write state completes.
// Reset (rst_n low, synchronous): state, configuration, write-byte and out_valid
// registers return to defaults, then a clearing pass zeroes every plane RAM byte,
// one byte a cycle, with in_stall high; configuration writes are taken throughout.
`default_nettype none
module planar_pixel_rop_engine #(
  parameter int unsigned PLANE_BYTES = ppre_pkg::PLANE_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [ppre_pkg::X_W-1:0]       in_pos_x,
  input  wire logic [ppre_pkg::Y_W-1:0]       in_pos_y,
  input  wire logic [3:0]                    in_pixel_color,
  input  wire logic [31:0]                   in_span_colors,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [3:0]                    out_read_color,
  output logic                               out_out_of_range,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ppre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ppre_pkg::LW_W-1:0]      cfg_data
);
  import ppre_pkg::*;

  localparam int unsigned AW = $clog2(PLANE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PLANE_BYTES - 1);

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r;
  logic [LW_W-1:0]  line_width_r;
  rop_t             raster_op_r;
  logic [1:0]       kind_r;
  logic [7:0]       mask_r;
  logic [7:0]       bits_r   [NUM_PLANES];
  logic [7:0]       bits_nxt [NUM_PLANES];
  logic [7:0]       mask_nxt;
  logic [7:0]       rdata    [NUM_PLANES];
  logic [AW-1:0]    addr_r;
  logic             bad_r;
  logic [AW-1:0]    lane_addr;
  lane_ctl_t        lane_ctl;
  logic             can_emit;
  logic             in_accept;
  logic             do_write;
  logic             emit;
  logic [3:0]       color_merge;
  logic             out_valid_r;
  logic [3:0]       out_read_color_r;
  logic             out_of_range_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
      raster_op_r  <= ROP_SET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_WIDTH: line_width_r <= cfg_data;
        REG_RASTER_OP:  raster_op_r  <= rop_t'(cfg_data[1:0]);
        default:        line_width_r <= line_width_r;
      endcase
    end
  end

  assign can_emit  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) || (state_r == ST_WRITE && can_emit));
  assign in_accept = in_valid && !in_stall;
  assign emit      = (state_r == ST_WRITE) && can_emit;
  assign do_write  = !bad_r && ((kind_r == KIND_PIX_WR) || (kind_r == KIND_SPAN_WR));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    lane_ctl.re    = 1'b0;
    lane_ctl.we    = 1'b0;
    lane_ctl.mask  = mask_r;
    lane_ctl.op    = raster_op_r;
    lane_addr      = addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        lane_ctl.we   = 1'b1;
        lane_ctl.mask = 8'hFF;
        lane_ctl.op   = ROP_SET;
        lane_addr     = clr_addr_r;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        lane_ctl.re = 1'b1;
        state_nxt   = ST_WRITE;
      end
      ST_WRITE: begin
        if (can_emit) begin
          lane_ctl.we = do_write;
          state_nxt   = in_accept ? ST_READ : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // split the item into per-plane write bytes
  always_comb begin
    mask_nxt = MASK_MSB >> in_pos_x[2:0];
    for (int p = 0; p < NUM_PLANES; p++) begin
      bits_nxt[p] = '0;
      if (in_kind == KIND_SPAN_WR) begin
        for (int n = 0; n < 8; n++) begin
          bits_nxt[p][7-n] = in_span_colors[4*n+p];
        end
      end else begin
        bits_nxt[p] = in_pixel_color[p] ? mask_nxt : 8'h00;
      end
    end
  end

  // zero write bytes feed the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        bits_r[p] <= '0;
      end
    end else if (in_accept) begin
      kind_r <= in_kind;
      mask_r <= (in_kind == KIND_SPAN_WR) ? 8'hFF : mask_nxt;
      for (int p = 0; p < NUM_PLANES; p++) begin
        bits_r[p] <= bits_nxt[p];
      end
    end
  end

  ppre_agen #(
    .PLANE_BYTES(PLANE_BYTES),
    .AW         (AW)
  ) u_agen (
    .clk       (clk),
    .load      (in_accept),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .line_width(line_width_r),
    .addr_r    (addr_r),
    .bad_r     (bad_r)
  );

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
    ppre_lane #(
      .PLANE_BYTES(PLANE_BYTES),
      .AW         (AW)
    ) u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .addr   (lane_addr),
      .bits   (bits_r[g]),
      .rdata_r(rdata[g])
    );
  end

  // merge the plane bits into one color
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      color_merge[p] = |(rdata[p] & mask_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_of_range_r   <= bad_r && (kind_r != KIND_NONE);
      out_read_color_r <= (!bad_r && kind_r == KIND_PIX_RD) ? color_merge : 4'h0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_color   = out_read_color_r;
  assign out_out_of_range = out_of_range_r;

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_READ)
    else $error("accepted item did not enter read");

  a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_WRITE)
    else $error("read not followed by write");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctl.we |-> (state_r == ST_WRITE || state_r == ST_CLEAR))
    else $error("plane write outside write or clear");

  a_reject_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_of_range_r |-> out_read_color_r == 4'h0)
    else $error("rejected item returned a color");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
module testbench;
  import ppre_pkg::*;

  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned PHASE_ACCESSES = 45;

  typedef struct packed {
    logic [1:0]     kind;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [3:0]     color;
    logic [31:0]    span;
  } access_t;

  typedef struct packed {
    logic [3:0] color;
    logic       oob;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_read_color;
  logic out_out_of_range;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LW_W-1:0] cfg_data = '0;
  access_t tx_item = '0;

  bit [7:0] shadow_plane [NUM_PLANES][PLANE_BYTES_DEF];
  logic [LW_W-1:0] lw_shadow = LINE_WIDTH_RST;
  rop_t rop_shadow = ROP_SET;

  access_t pending_access[$];
  pixel_result_t predicted_result[$];

  bit tx_busy = 1'b0;
  bit rx_busy = 1'b0;
  int unsigned hot_x = 0;
  int unsigned hot_y = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_hold = 0;
  int unsigned n_access = 0;
  int unsigned n_read = 0;
  int unsigned n_span = 0;
  int unsigned n_reject = 0;
  int unsigned n_result = 0;
  int unsigned errors = 0;

  int unsigned phase_lw [NUM_PHASES] = '{640, 640, 640, 8, 1024, 1024, 100, 2047, 64, 1024};
  rop_t phase_rop [NUM_PHASES] = '{ROP_SET, ROP_XOR, ROP_AND, ROP_OR, ROP_OR, ROP_AND,
                                   ROP_XOR, ROP_SET, ROP_XOR, ROP_XOR};
  bit phase_busy [NUM_PHASES] = '{0, 0, 0, 0, 0, 1, 0, 0, 1, 0};

  wire logic [1:0]     in_kind_w;
  wire logic [X_W-1:0] in_pos_x_w;
  wire logic [Y_W-1:0] in_pos_y_w;
  wire logic [3:0]     in_pixel_color_w;
  wire logic [31:0]    in_span_colors_w;
  assign {in_kind_w, in_pos_x_w, in_pos_y_w, in_pixel_color_w, in_span_colors_w} = tx_item;

  planar_pixel_rop_engine DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind_w),
    .in_pos_x         (in_pos_x_w),
    .in_pos_y         (in_pos_y_w),
    .in_pixel_color   (in_pixel_color_w),
    .in_span_colors   (in_span_colors_w),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_color   (out_read_color),
    .out_out_of_range (out_out_of_range),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void rop_byte(int p, int unsigned addr, logic [7:0] mask,
                                   logic [7:0] bits);
    logic [7:0] old;
    logic [7:0] val;
    old = shadow_plane[p][addr];
    case (rop_shadow)
      ROP_SET: val = bits;
      ROP_AND: val = old & bits;
      ROP_OR:  val = old | bits;
      default: val = old ^ bits;
    endcase
    shadow_plane[p][addr] = (old & ~mask) | (val & mask);
  endfunction

  function automatic pixel_result_t apply_access(access_t a);
    pixel_result_t r;
    int unsigned bpl;
    int unsigned addr;
    logic [7:0] mask;
    logic [7:0] bits;
    r = '0;
    bpl = lw_shadow >> 3;
    addr = a.y * bpl + (a.x >> 3);
    mask = MASK_MSB >> a.x[2:0];
    if (a.kind == KIND_NONE) return r;
    if ((a.x >> 3) >= bpl || addr >= PLANE_BYTES_DEF) begin
      r.oob = 1'b1;
      return r;
    end
    for (int p = 0; p < NUM_PLANES; p++) begin
      case (a.kind)
        KIND_PIX_WR: rop_byte(p, addr, mask, a.color[p] ? mask : 8'h00);
        KIND_PIX_RD: r.color[p] = |(shadow_plane[p][addr] & mask);
        default: begin
          for (int n = 0; n < 8; n++) bits[7-n] = a.span[4*n+p];
          rop_byte(p, addr, 8'hFF, bits);
        end
      endcase
    end
    return r;
  endfunction

  function automatic access_t random_access();
    access_t a;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) a.kind = KIND_PIX_WR;
    else if (pick < 65) a.kind = KIND_PIX_RD;
    else if (pick < 93) a.kind = KIND_SPAN_WR;
    else a.kind = KIND_NONE;
    a.color = 4'($urandom);
    a.span = $urandom;
    if ($urandom_range(0, 4) != 0) begin
      a.x = X_W'(hot_x + $urandom_range(0, 15));
      a.y = Y_W'(hot_y + $urandom_range(0, 3));
    end else begin
      a.x = X_W'($urandom);
      a.y = Y_W'($urandom);
    end
    return a;
  endfunction

  task automatic push_access(logic [1:0] kind, int unsigned x, int unsigned y,
                             logic [3:0] color, logic [31:0] span);
    pending_access.push_back('{kind, X_W'(x), Y_W'(y), color, span});
  endtask

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("mismatch on %s at result %0d: expected %0d, got %0d", what, n_result, want, got);
    errors++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [LW_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_LINE_WIDTH) lw_shadow = val;
    else rop_shadow = rop_t'(val[1:0]);
  endtask

  task automatic drain();
    while (pending_access.size() > 0 || in_valid || predicted_result.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // driver: hold the item while stalled, then advance after a random gap
  always @(posedge clk) begin
    bit sending;
    pixel_result_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      sending = in_valid;
      if (in_valid && !in_stall) begin
        r = apply_access(tx_item);
        predicted_result.push_back(r);
        n_access++;
        if (tx_item.kind == KIND_PIX_RD) n_read++;
        if (tx_item.kind == KIND_SPAN_WR) n_span++;
        if (r.oob) n_reject++;
        tx_gap = tx_busy ? 0 : $urandom_range(0, 6);
        sending = 1'b0;
      end
      if (!sending) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_access.size() > 0) begin
          tx_item <= pending_access.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted item against the oldest prediction
  always @(posedge clk) begin
    bit hold;
    pixel_result_t want;
    hold = 1'b0;
    if (!rst_n) begin
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_result++;
        if (predicted_result.size() == 0) begin
          report_mismatch("result with nothing pending", 0, 1);
        end else begin
          want = predicted_result.pop_front();
          if (out_read_color !== want.color)
            report_mismatch("read_color", want.color, out_read_color);
          if (out_out_of_range !== want.oob)
            report_mismatch("out_of_range", want.oob, out_out_of_range);
        end
        rx_hold = rx_busy ? 0 : $urandom_range(0, 6);
      end
      if (rx_hold > 0) begin
        hold = 1'b1;
        rx_hold--;
      end
    end
    out_stall <= hold;
  end

  initial begin
    int unsigned bpl;
    int unsigned rows;
    int unsigned blocks;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph == 0 || phase_lw[ph] != lw_shadow) begin
        cfg_write(REG_LINE_WIDTH, LW_W'(phase_lw[ph]));
        bpl = phase_lw[ph] >> 3;
        blocks = bpl < 128 ? bpl : 128;
        hot_x = 8 * $urandom_range(0, blocks > 2 ? blocks - 2 : 0);
        rows = PLANE_BYTES_DEF / bpl;
        rows = rows > 512 ? 512 : rows;
        hot_y = $urandom_range(0, rows > 4 ? rows - 4 : 0);
      end
      cfg_write(REG_RASTER_OP, LW_W'(phase_rop[ph]));
      tx_busy = phase_busy[ph];
      rx_busy = phase_busy[ph];
      if (ph == 0) begin
        push_access(KIND_PIX_WR, 0, 0, 4'hF, 0);
        push_access(KIND_PIX_RD, 0, 0, 0, 0);
        push_access(KIND_PIX_WR, 7, 0, 4'h5, 0);
        push_access(KIND_PIX_RD, 7, 0, 0, 0);
        push_access(KIND_PIX_RD, 1, 0, 0, 0);
        push_access(KIND_PIX_WR, 0, 0, 4'h0, 0);
        push_access(KIND_PIX_RD, 0, 0, 0, 0);
        push_access(KIND_PIX_WR, 639, 408, 4'hA, 0);
        push_access(KIND_PIX_RD, 639, 408, 0, 0);
        push_access(KIND_PIX_WR, 639, 409, 4'h3, 0);
        push_access(KIND_PIX_WR, 0, 409, 4'h9, 0);
        push_access(KIND_PIX_RD, 0, 409, 0, 0);
        push_access(KIND_PIX_WR, 640, 0, 4'hF, 0);
        push_access(KIND_PIX_RD, 1023, 511, 0, 0);
        push_access(KIND_PIX_WR, 0, 511, 4'hF, 0);
        push_access(KIND_SPAN_WR, 5, 1, 0, 32'h7654_3210);
        push_access(KIND_PIX_RD, 0, 1, 0, 0);
        push_access(KIND_PIX_RD, 3, 1, 0, 0);
        push_access(KIND_PIX_RD, 7, 1, 0, 0);
        push_access(KIND_SPAN_WR, 1016, 2, 0, 32'hFFFF_FFFF);
        push_access(KIND_SPAN_WR, 8, 3, 0, 32'hFFFF_FFFF);
        push_access(KIND_PIX_RD, 15, 3, 0, 0);
        push_access(KIND_NONE, 1023, 511, 4'hF, 32'hFFFF_FFFF);
      end else begin
        for (int i = 0; i < PHASE_ACCESSES; i++) pending_access.push_back(random_access());
      end
    end
    drain();
    $display("%0d accesses over %0d line width and raster op settings", n_access, NUM_PHASES);
    $display("%0d reads, %0d span writes, %0d rejected", n_read, n_span, n_reject);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", predicted_result.size());
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
sv/ppre_pkg.sv
sv/ppre_agen.sv
sv/ppre_lane.sv
sv/planar_pixel_rop_engine.sv
tb/sv/testbench.sv
